/* sv/tgarle_pkg.sv */
package tgarle_pkg;

	// register indexes on the config port
	typedef enum logic [1:0] {
		REG_WIDTH    = 2'd0,
		REG_HEIGHT   = 2'd1,
		REG_TOP_DOWN = 2'd2,
		REG_NONE     = 2'd3
	} cfg_reg_t;

	// position of the next color byte within a pixel
	typedef enum logic [1:0] {
		BYTE_BLUE  = 2'd0,
		BYTE_GREEN = 2'd1,
		BYTE_RED   = 2'd2,
		BYTE_SPARE = 2'd3
	} pix_byte_t;

	localparam int unsigned DIM_W  = 16;
	localparam int unsigned LEN_W  = 8;
	localparam int unsigned AREA_W = 2 * DIM_W;

	localparam int unsigned HDR_RUN_BIT = 7;
	localparam logic [6:0]  HDR_COUNT_MASK = 7'h7F;

	// one emitted result as seen by the position tracker
	typedef struct packed {
		logic             valid;
		logic [LEN_W-1:0] len;
	} adv_t;

	// current raster position handed back to the parser
	typedef struct packed {
		logic [DIM_W-1:0]  col;
		logic [DIM_W-1:0]  row;
		logic [AREA_W-1:0] left;
	} pos_t;

endpackage

/* sv/tgarle_pos_track.sv */
module tgarle_pos_track import tgarle_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [DIM_W-1:0] w_eff,
	input  logic [DIM_W-1:0] h_eff,
	input  logic             restart,
	input  adv_t             adv,
	output pos_t             pos
);

	localparam int unsigned REM_W = DIM_W + 1;
	localparam int unsigned DIV_W = DIM_W + 9;

	logic [AREA_W-1:0] total_q;
	logic [AREA_W-1:0] pix_q;
	logic [DIM_W-1:0]  col_q;
	logic [DIM_W-1:0]  row_q;
	logic [REM_W-1:0]  rem_q;
	logic [1:0]        grp_q;
	logic              busy_q;

	logic [REM_W-1:0]  rem_d;
	logic [DIM_W-1:0]  row_d;
	logic [DIM_W-1:0]  col_inc;

	// three restoring-division steps per cycle, quotient bits 8..0
	always_comb begin
		logic [DIV_W-1:0] rem_w;
		logic [DIV_W-1:0] dvs;
		logic [3:0]       k;
		rem_w = DIV_W'(rem_q);
		row_d = row_q;
		for (int i = 0; i < 3; i++) begin
			k = 4'(grp_q) * 4'd3 + 4'd2 - 4'(i);
			dvs = DIV_W'(w_eff) << k;
			if (rem_w >= dvs) begin
				rem_w = rem_w - dvs;
				row_d = row_d + (DIM_W'(1) << k);
			end
		end
		rem_d = rem_w[REM_W-1:0];
	end

	assign col_inc = col_q + DIM_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= AREA_W'(1);
			pix_q   <= '0;
			col_q   <= '0;
			row_q   <= '0;
			rem_q   <= '0;
			grp_q   <= '0;
			busy_q  <= 1'b0;
		end else begin
			total_q <= AREA_W'(w_eff) * AREA_W'(h_eff);
			if (restart) begin
				pix_q  <= '0;
				col_q  <= '0;
				row_q  <= '0;
				busy_q <= 1'b0;
			end else if (adv.valid) begin
				pix_q <= pix_q + AREA_W'(adv.len);
				if (adv.len == LEN_W'(1)) begin
					if (col_inc == w_eff) begin
						col_q <= '0;
						row_q <= row_q + DIM_W'(1);
					end else begin
						col_q <= col_inc;
					end
				end else begin
					rem_q  <= REM_W'(col_q) + REM_W'(adv.len);
					grp_q  <= 2'd2;
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				rem_q <= rem_d;
				row_q <= row_d;
				grp_q <= grp_q - 2'd1;
				if (grp_q == 2'd0) begin
					busy_q <= 1'b0;
					col_q  <= rem_d[DIM_W-1:0];
				end
			end
		end
	end

	assign pos.col  = col_q;
	assign pos.row  = row_q;
	assign pos.left = total_q - pix_q;

endmodule

/* sv/tga_rle_pixel_decoder_top.sv */
// A word is registered at acceptance and its result, if any, is loaded into the
// output register when the held word moves on.
// One byte per cycle while the output is not stalled on an untaken result; the
// run-advance divider finishes inside the 4 bytes between a run and the next result.
// Reset (arst_n low): width and height 1, bottom-up, parser awaits a header.
module tga_rle_pixel_decoder_top import tgarle_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	// compressed byte stream
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [7:0]       data_byte,
	// decoded runs
	output logic             out_valid,
	input  logic             out_stall,
	output logic [7:0]       red,
	output logic [7:0]       green,
	output logic [7:0]       blue,
	output logic [DIM_W-1:0] start_x,
	output logic [DIM_W-1:0] start_y,
	output logic [LEN_W-1:0] run_length,
	output logic             frame_done,
	output logic             overrun,
	// configuration
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [DIM_W-1:0] cfg_data
);

	// config registers
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic             top_down_q;
	logic [DIM_W-1:0] w_eff;
	logic [DIM_W-1:0] h_eff;
	logic             cfg_hit;

	// input stage
	logic             valid_s1;
	logic [7:0]       byte_s1;

	// packet parser
	logic             expect_hdr_q;
	logic             is_run_q;
	logic [LEN_W-1:0] pkt_left_q;
	pix_byte_t        byte_idx_q;
	logic [7:0]       blue_q;
	logic [7:0]       green_q;

	// result register
	logic             out_valid_q;
	logic [7:0]       red_q;
	logic [7:0]       green_out_q;
	logic [7:0]       blue_out_q;
	logic [DIM_W-1:0] start_x_q;
	logic [DIM_W-1:0] start_y_q;
	logic [LEN_W-1:0] run_length_q;
	logic             frame_done_q;
	logic             overrun_q;

	logic             accept;
	logic             emits;
	logic             out_busy;
	logic             adv_s1;
	logic             fire;
	logic [LEN_W-1:0] want;
	logic [LEN_W-1:0] pkt_rest;
	logic             more;
	logic             clamp;
	logic [LEN_W-1:0] len;
	logic             done;
	logic [DIM_W-1:0] row_out;
	adv_t             adv;
	pos_t             pos;

	assign w_eff   = (width_q == '0) ? DIM_W'(1) : width_q;
	assign h_eff   = (height_q == '0) ? DIM_W'(1) : height_q;
	// any write to a real register restarts frame and parser
	assign cfg_hit = cfg_we && (cfg_index != REG_NONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= DIM_W'(1);
			height_q   <= DIM_W'(1);
			top_down_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH:    width_q    <= cfg_data;
				REG_HEIGHT:   height_q   <= cfg_data;
				REG_TOP_DOWN: top_down_q <= cfg_data[0];
				default:      ;
			endcase
		end
	end

	// Handshake: the held word moves on unless it makes a result while the
	// output register still holds an untaken one.
	assign emits    = !expect_hdr_q && (byte_idx_q == BYTE_RED);
	assign out_busy = out_valid_q && out_stall;
	assign adv_s1   = valid_s1 && !(emits && out_busy);
	assign in_stall = valid_s1 && !adv_s1;
	assign accept   = in_valid && !in_stall;
	assign fire     = adv_s1 && emits;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= data_byte;
		end
	end

	// Pixel count requested by this result; a raw packet still owing pixels
	// after this one flags an overrun if the frame ends here.
	assign pkt_rest = (pkt_left_q != '0) ? pkt_left_q - LEN_W'(1) : '0;
	always_comb begin
		if (is_run_q) begin
			want = (pkt_left_q != '0) ? pkt_left_q : LEN_W'(1);
			more = 1'b0;
		end else begin
			want = LEN_W'(1);
			more = (pkt_rest != '0);
		end
	end

	// clamp against the pixels left in the frame (always at least one)
	assign clamp   = AREA_W'(want) > pos.left;
	assign len     = clamp ? pos.left[LEN_W-1:0] : want;
	assign done    = (AREA_W'(len) == pos.left);
	assign row_out = top_down_q ? pos.row : (h_eff - DIM_W'(1) - pos.row);

	assign adv.valid = fire && !done;
	assign adv.len   = len;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_hdr_q <= 1'b1;
			is_run_q     <= 1'b0;
			pkt_left_q   <= '0;
			byte_idx_q   <= BYTE_BLUE;
			blue_q       <= '0;
			green_q      <= '0;
		end else if (cfg_hit) begin
			expect_hdr_q <= 1'b1;
			is_run_q     <= 1'b0;
			pkt_left_q   <= '0;
			byte_idx_q   <= BYTE_BLUE;
		end else if (adv_s1) begin
			if (expect_hdr_q) begin
				expect_hdr_q <= 1'b0;
				is_run_q     <= byte_s1[HDR_RUN_BIT];
				pkt_left_q   <= LEN_W'(byte_s1[6:0] & HDR_COUNT_MASK) + LEN_W'(1);
				byte_idx_q   <= BYTE_BLUE;
			end else begin
				case (byte_idx_q)
					BYTE_BLUE: begin
						blue_q     <= byte_s1;
						byte_idx_q <= BYTE_GREEN;
					end
					BYTE_GREEN: begin
						green_q    <= byte_s1;
						byte_idx_q <= BYTE_RED;
					end
					default: begin
						byte_idx_q <= BYTE_BLUE;
						if (done) begin
							// frame end: drop the rest of the packet
							expect_hdr_q <= 1'b1;
							is_run_q     <= 1'b0;
							pkt_left_q   <= '0;
						end else if (is_run_q) begin
							expect_hdr_q <= 1'b1;
							pkt_left_q   <= '0;
						end else begin
							pkt_left_q <= pkt_rest;
							if (pkt_rest == '0) begin
								expect_hdr_q <= 1'b1;
							end
						end
					end
				endcase
			end
		end
	end

	tgarle_pos_track u_pos (
		.clk     (clk),
		.arst_n  (arst_n),
		.w_eff   (w_eff),
		.h_eff   (h_eff),
		.restart (cfg_hit || (fire && done)),
		.adv     (adv),
		.pos     (pos)
	);

	// output register: loads when a result fires, clears when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			red_q        <= byte_s1;
			green_out_q  <= green_q;
			blue_out_q   <= blue_q;
			start_x_q    <= pos.col;
			start_y_q    <= row_out;
			run_length_q <= len;
			frame_done_q <= done;
			overrun_q    <= clamp || (done && more);
		end
	end

	assign out_valid  = out_valid_q;
	assign red        = red_q;
	assign green      = green_out_q;
	assign blue       = blue_out_q;
	assign start_x    = start_x_q;
	assign start_y    = start_y_q;
	assign run_length = run_length_q;
	assign frame_done = frame_done_q;
	assign overrun    = overrun_q;

endmodule

/* tb/sv/tga_rle_run_checker.sv */
`timescale 1ns / 1ps
module tga_rle_run_checker import tgarle_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_stall,
	input  logic [7:0]       data_byte,
	input  logic             out_valid,
	input  logic             out_stall,
	input  logic [7:0]       red,
	input  logic [7:0]       green,
	input  logic [7:0]       blue,
	input  logic [DIM_W-1:0] start_x,
	input  logic [DIM_W-1:0] start_y,
	input  logic [LEN_W-1:0] run_length,
	input  logic             frame_done,
	input  logic             overrun,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [DIM_W-1:0] cfg_data,
	output int               mismatch_count,
	output int               runs_due
);

	typedef struct packed {
		logic [7:0]       red;
		logic [7:0]       green;
		logic [7:0]       blue;
		logic [DIM_W-1:0] start_x;
		logic [DIM_W-1:0] start_y;
		logic [LEN_W-1:0] run_length;
		logic             frame_done;
		logic             overrun;
	} run_word_t;

	run_word_t expected_runs[$];

	logic [DIM_W-1:0] img_w;
	logic [DIM_W-1:0] img_h;
	logic             img_top_down;

	logic             want_header;
	logic             pkt_is_run;
	logic [LEN_W-1:0] pkt_left;
	pix_byte_t        next_byte;
	logic [7:0]       blue_hold;
	logic [7:0]       green_hold;
	logic [DIM_W-1:0] col_pos;
	logic [DIM_W-1:0] row_pos;

	task automatic rewind_frame();
		want_header = 1'b1;
		pkt_is_run  = 1'b0;
		pkt_left    = '0;
		next_byte   = BYTE_BLUE;
		col_pos     = '0;
		row_pos     = '0;
	endtask

	// one run word starting at the current raster position, clamped to the frame end
	task automatic predict_run(input logic [7:0] r, input int unsigned want,
			input bit more_pixels);
		longint unsigned w, h, total, pos, left, len, nxt;
		bit over, done;
		run_word_t e;
		w = (img_w == 0) ? 1 : img_w;
		h = (img_h == 0) ? 1 : img_h;
		total = w * h;
		pos = longint'(row_pos) * w + col_pos;
		left = (pos < total) ? total - pos : 1;
		len = want;
		over = 1'b0;
		if (len > left) begin
			len = left;
			over = 1'b1;
		end
		done = (len == left);
		if (done && more_pixels)
			over = 1'b1;
		e.red = r;
		e.green = green_hold;
		e.blue = blue_hold;
		e.start_x = col_pos;
		if (img_top_down)
			e.start_y = row_pos;
		else
			e.start_y = (row_pos < h) ? DIM_W'(h - 1 - row_pos) : '0;
		e.run_length = LEN_W'(len);
		e.frame_done = done;
		e.overrun = over;
		expected_runs.push_back(e);
		if (done) begin
			rewind_frame();
		end else begin
			nxt = pos + len;
			row_pos = DIM_W'(nxt / w);
			col_pos = DIM_W'(nxt % w);
		end
	endtask

	task automatic decode_byte(input logic [7:0] b);
		logic [LEN_W-1:0] rest;
		if (want_header) begin
			want_header = 1'b0;
			pkt_is_run = b[HDR_RUN_BIT];
			pkt_left = LEN_W'({1'b0, b[6:0] & HDR_COUNT_MASK}) + 8'd1;
			next_byte = BYTE_BLUE;
		end else begin
			case (next_byte)
				BYTE_BLUE: begin
					blue_hold = b;
					next_byte = BYTE_GREEN;
				end
				BYTE_GREEN: begin
					green_hold = b;
					next_byte = BYTE_RED;
				end
				default: begin
					next_byte = BYTE_BLUE;
					if (pkt_is_run) begin
						rest = pkt_left;
						pkt_left = '0;
						want_header = 1'b1;
						predict_run(b, (rest != 0) ? rest : 1, 1'b0);
					end else begin
						rest = (pkt_left != 0) ? pkt_left - 8'd1 : '0;
						pkt_left = rest;
						if (rest == 0)
							want_header = 1'b1;
						predict_run(b, 1, rest != 0);
					end
				end
			endcase
		end
	endtask

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			mismatch_count++;
			$error("%s: expected %0d, got %0d", name, want, got);
		end
	endtask

	task automatic take_run();
		run_word_t e;
		if (expected_runs.size() == 0) begin
			mismatch_count++;
			$error("run word with nothing expected");
		end else begin
			e = expected_runs.pop_front();
			check_field("red", e.red, red);
			check_field("green", e.green, green);
			check_field("blue", e.blue, blue);
			check_field("start_x", e.start_x, start_x);
			check_field("start_y", e.start_y, start_y);
			check_field("run_length", e.run_length, run_length);
			check_field("frame_done", e.frame_done, frame_done);
			check_field("overrun", e.overrun, overrun);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w = DIM_W'(1);
			img_h = DIM_W'(1);
			img_top_down = 1'b0;
			blue_hold = '0;
			green_hold = '0;
			rewind_frame();
			expected_runs.delete();
			mismatch_count = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_WIDTH: begin
						img_w = cfg_data;
						rewind_frame();
					end
					REG_HEIGHT: begin
						img_h = cfg_data;
						rewind_frame();
					end
					REG_TOP_DOWN: begin
						img_top_down = cfg_data[0];
						rewind_frame();
					end
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				decode_byte(data_byte);
			if (out_valid && !out_stall)
				take_run();
		end
		runs_due = expected_runs.size();
	end

endmodule

/* tb/sv/tga_rle_pixel_decoder_top_tb.sv */
`timescale 1ns / 1ps
module tga_rle_pixel_decoder_top_tb;
	import tgarle_pkg::*;

	// cycles with no word moving on any port before the run is declared hung
	localparam int unsigned STALL_LIMIT = 3000;
	// length of the forced receiver hold-off that backs the block up
	localparam int unsigned LONG_HOLD   = 300;
	// pipeline is 2 deep; give header/color bytes time to retire before a write
	localparam int unsigned SETTLE      = 4;

	logic             clk;
	logic             arst_n     = 1'b0;
	logic             in_valid   = 1'b0;
	logic             in_stall;
	logic [7:0]       data_byte  = '0;
	logic             out_valid;
	logic             out_stall  = 1'b0;
	logic [7:0]       red;
	logic [7:0]       green;
	logic [7:0]       blue;
	logic [DIM_W-1:0] start_x;
	logic [DIM_W-1:0] start_y;
	logic [LEN_W-1:0] run_length;
	logic             frame_done;
	logic             overrun;
	logic             cfg_we     = 1'b0;
	logic [1:0]       cfg_index  = REG_WIDTH;
	logic [DIM_W-1:0] cfg_data   = '0;

	int mismatch_count;
	int runs_due;

	// idle percentages for the two sides, changed between test sections
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	// hold-off handshake between the stimulus and the receiver process
	int hold_requests = 0;
	int holds_served  = 0;
	int hold_left     = 0;

	// stimulus-side view of the frame, only used to keep packets aligned
	longint unsigned frame_pixels = 1;
	longint unsigned pixels_left  = 1;
	int unsigned     bytes_sent   = 0;
	int unsigned     quiet_cycles = 0;

	// 1x1 bottom-up after reset: every pixel ends the frame
	logic [7:0] opening [20] = '{
		8'h80, 8'h00, 8'h00, 8'h00,   // run of one, black
		8'hFF, 8'hFF, 8'hFF, 8'hFF,   // run of 128, clamped
		8'h00, 8'h12, 8'h34, 8'h56,   // raw of one
		8'h7F, 8'hAA, 8'h55, 8'hC3,   // raw of 128, rest dropped
		8'h81, 8'h01, 8'h02, 8'h03    // run of two, clamped
	};

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	tga_rle_pixel_decoder_top u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.start_x    (start_x),
		.start_y    (start_y),
		.run_length (run_length),
		.frame_done (frame_done),
		.overrun    (overrun),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	tga_rle_run_checker u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.data_byte      (data_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.red            (red),
		.green          (green),
		.blue           (blue),
		.start_x        (start_x),
		.start_y        (start_y),
		.run_length     (run_length),
		.frame_done     (frame_done),
		.overrun        (overrun),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.runs_due       (runs_due)
	);

	// Receiver: random stall at the current rate, or a long counted hold-off
	// whenever the stimulus asks for one.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (hold_requests != holds_served) begin
			holds_served++;
			hold_left = LONG_HOLD - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Watchdog: any word moving on either channel, or a register write, counts
	// as progress.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offer one byte; called and returns at a falling edge. Valid stays high
	// across back-to-back words so it is never dropped and raised in one step.
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		do
			@(posedge clk);
		while (in_stall);
		bytes_sent++;
		@(negedge clk);
	endtask

	// Stop offering and wait until every predicted run word has come out.
	task automatic quiesce();
		in_valid <= 1'b0;
		@(negedge clk);
		while (runs_due != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [DIM_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
	endtask

	task automatic set_frame(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
			input logic td);
		longint unsigned wf, hf;
		quiesce();
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		write_reg(REG_TOP_DOWN, {15'd0, td});
		cfg_we <= 1'b0;
		// zero width/height behave as one
		wf = (w == 0) ? 1 : w;
		hf = (h == 0) ? 1 : h;
		frame_pixels = wf * hf;
		pixels_left = frame_pixels;
	endtask

	task automatic advance_frame(input longint unsigned n);
		if (n >= pixels_left)
			pixels_left = frame_pixels;
		else
			pixels_left -= n;
	endtask

	// Mostly well-formed packets with random content; a few bursts of loose
	// bytes knock the parser out of step.
	task automatic send_packet();
		int unsigned cnt;
		longint unsigned pix;
		if ($urandom_range(99) < 7) begin
			repeat ($urandom_range(4, 1)) send_byte(8'($urandom));
			return;
		end
		if ($urandom_range(1) == 1) begin
			cnt = $urandom_range(127);
			send_byte({1'b1, 7'(cnt)});
			repeat (3) send_byte(8'($urandom));
			advance_frame(cnt + 1);
		end else begin
			// long raw packets only near a frame end, where they get clamped
			if (pixels_left <= 16 && $urandom_range(3) == 0)
				cnt = $urandom_range(127);
			else
				cnt = $urandom_range(5);
			pix = (cnt + 1 > pixels_left) ? pixels_left : cnt + 1;
			send_byte({1'b0, 7'(cnt)});
			repeat (3 * pix) send_byte(8'($urandom));
			advance_frame(pix);
		end
	endtask

	task automatic send_random(input int unsigned n);
		int unsigned target;
		target = bytes_sent + n;
		while (bytes_sent < target)
			send_packet();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// sender mostly busy, receiver mostly stalled
		send_idle_pct = 15;
		recv_idle_pct = 79;
		foreach (opening[i])
			send_byte(opening[i]);

		// zero sizes act as one; raw of three overruns
		set_frame(16'd0, 16'd0, 1'b1);
		send_byte(8'h02);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_random(30);

		// write lands in the middle of a raw packet and restarts the parser
		set_frame(16'd4, 16'd3, 1'b1);
		send_byte(8'h05);
		repeat (3) send_byte(8'($urandom));

		// largest frame, bottom-up; receiver backs up while bytes keep coming
		set_frame(16'hFFFF, 16'hFFFF, 1'b0);
		hold_requests++;
		send_random(40);

		// sender mostly idle, receiver mostly ready
		send_idle_pct = 79;
		recv_idle_pct = 15;
		set_frame(16'hFFFF, 16'hFFFF, 1'b1);
		send_random(30);
		set_frame(16'd3, 16'd2, 1'b0);
		send_random(50);

		// write to the unused index mid-packet must not restart anything
		quiesce();
		send_byte(8'h83);
		send_byte(8'h11);
		quiesce();
		write_reg(REG_NONE, 16'hFFFF);
		cfg_we <= 1'b0;
		send_byte(8'h22);
		send_byte(8'h33);
		advance_frame(4);

		set_frame(16'd1, 16'd7, 1'b1);
		send_random(30);

		// no idling on either side
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_frame(16'd5, 16'd4, 1'b0);
		hold_requests++;
		send_random(40);
		repeat (3) begin
			set_frame(16'($urandom_range(12, 1)), 16'($urandom_range(6, 1)),
				1'($urandom_range(1)));
			send_random(30);
		end
		set_frame(16'hFFFF, 16'd1, 1'b1);
		send_random(30);

		// drain, then let the pipeline settle before the verdict
		in_valid <= 1'b0;
		@(negedge clk);
		while (runs_due != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (mismatch_count == 0 && runs_due == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
